### hw/rtl/push_to_talk_voice_controller_core_macros.svh
// ----------------------------------------------------------------------------
// Push-to-talk controller assertion macros
// Shared same-cycle and next-cycle implication assertion forms.
// ----------------------------------------------------------------------------
`ifndef PUSH_TO_TALK_VOICE_CONTROLLER_CORE_MACROS_SVH
`define PUSH_TO_TALK_VOICE_CONTROLLER_CORE_MACROS_SVH

// same-cycle implication
`define PTT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ptt assertion failed");

// next-cycle implication
`define PTT_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ptt assertion failed");

`endif

### hw/rtl/ptt_pkg.sv
// ----------------------------------------------------------------------------
// Push-to-talk controller package
// Mode codes, operation codes, register indexes and control structs.
// ----------------------------------------------------------------------------
package ptt_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE       = 3'd0,
      MODE_CONNECTING = 3'd1,
      MODE_READY      = 3'd2,
      MODE_LISTENING  = 3'd3,
      MODE_PROCESSING = 3'd4,
      MODE_SPEAKING   = 3'd5
   } mode_type;

   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_AUDIO = 3'd1;
   localparam logic [2:0] OP_SPEAK = 3'd2;
   localparam logic [2:0] OP_DONE  = 3'd3;
   localparam logic [2:0] OP_ERROR = 3'd4;

   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEBOUNCE = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT  = 1'd1;

   localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [31:0] TIMEOUT_RESET  = 32'd30000;

   typedef struct packed {
      mode_type mode;
      logic     mode_changed;
      logic     request_connect;
      logic     send_config;
      logic     send_end_audio;
      logic     capture_enable;
   } meta_type;

   typedef struct packed {
      logic     item_load;
      logic     ring_clear;
      logic     ring_put;
      logic     ring_take;
      logic     lo_capture;
      logic     set_change;
      logic     set_release;
      logic     out_load;
      logic     out_sample_valid;
      logic     out_last;
      meta_type meta;
   } cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       wifi;
      logic       link;
      logic       btn;
      logic       muted;
      logic       deb_ok;
      logic       to_ok;
      logic       fill_zero;
      logic       rem_zero;
      logic       out_free;
   } stat_type;

endpackage

### hw/rtl/ptt_req_if.sv
// ----------------------------------------------------------------------------
// Push-to-talk request channel
// Valid/ready channel carrying one input word.
// ----------------------------------------------------------------------------
interface ptt_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic [31:0] now_ms;
   logic        wifi_up;
   logic        link_up;
   logic        button_down;
   logic        muted;
   logic [7:0]  data_byte;

   modport source (output valid, operation, now_ms, wifi_up, link_up, button_down, muted,
                   data_byte, input ready);
   modport sink (input valid, operation, now_ms, wifi_up, link_up, button_down, muted,
                 data_byte, output ready);
endinterface

### hw/rtl/ptt_rsp_if.sv
// ----------------------------------------------------------------------------
// Push-to-talk response channel
// Valid/ready channel carrying one result word.
// ----------------------------------------------------------------------------
interface ptt_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         mode;
   logic               mode_changed;
   logic signed [15:0] sample;
   logic               sample_valid;
   logic               last;
   logic               request_connect;
   logic               send_config;
   logic               send_end_audio;
   logic               capture_enable;

   modport source (output valid, mode, mode_changed, sample, sample_valid, last,
                   request_connect, send_config, send_end_audio, capture_enable,
                   input ready);
   modport sink (input valid, mode, mode_changed, sample, sample_valid, last,
                 request_connect, send_config, send_end_audio, capture_enable,
                 output ready);
endinterface

### hw/rtl/ptt_ctrl.sv
// ----------------------------------------------------------------------------
// Push-to-talk controller sequencer
// Owns the link mode, button and reply flags; sequences each word.
// ----------------------------------------------------------------------------
module ptt_ctrl #(
   parameter int CHUNK_SAMPLES = 32,
   localparam int SW = $clog2(CHUNK_SAMPLES + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ptt_pkg::stat_type  stat,
   input  logic [SW-1:0]      samples,
   output ptt_pkg::cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_EVAL, ST_OUT, ST_RD_LO, ST_RD_HI, ST_EMIT
   } seq_type;

   seq_type            state_ff, state_in;
   ptt_pkg::mode_type  mode_ff, mode_in;
   logic               held_ff, held_in;
   logic               await_ff, await_in;
   ptt_pkg::meta_type  meta_ff, meta_in;
   logic [SW-1:0]      cnt_ff, cnt_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      held_in  = held_ff;
      await_in = await_ff;
      meta_in  = meta_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      cmd.meta = meta_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.item_load = 1'b1;
               state_in      = ST_EVAL;
            end
         end
         ST_EVAL: begin
            meta_in  = '0;
            state_in = ST_OUT;
            case (stat.op)
               ptt_pkg::OP_TICK: begin
                  case (mode_ff)
                     ptt_pkg::MODE_IDLE: begin
                        if (stat.wifi) begin
                           mode_in                 = ptt_pkg::MODE_CONNECTING;
                           meta_in.request_connect = 1'b1;
                        end
                     end
                     ptt_pkg::MODE_CONNECTING: begin
                        if (stat.link) begin
                           mode_in             = ptt_pkg::MODE_READY;
                           meta_in.send_config = 1'b1;
                        end
                        if (!stat.wifi) mode_in = ptt_pkg::MODE_IDLE;
                     end
                     ptt_pkg::MODE_READY: begin
                        if (stat.btn && !held_ff && stat.deb_ok) begin
                           held_in        = 1'b1;
                           cmd.set_change = 1'b1;
                           cmd.ring_clear = 1'b1;
                           mode_in        = ptt_pkg::MODE_LISTENING;
                        end
                        if (!stat.btn && held_ff) begin
                           held_in        = 1'b0;
                           cmd.set_change = 1'b1;
                        end
                        if (!stat.link) mode_in = ptt_pkg::MODE_CONNECTING;
                     end
                     ptt_pkg::MODE_LISTENING: begin
                        meta_in.capture_enable = !stat.muted;
                        if (!stat.btn && stat.deb_ok) begin
                           held_in                = 1'b0;
                           await_in               = 1'b1;
                           cmd.set_change         = 1'b1;
                           cmd.set_release        = 1'b1;
                           meta_in.send_end_audio = 1'b1;
                           mode_in                = ptt_pkg::MODE_PROCESSING;
                        end
                     end
                     ptt_pkg::MODE_PROCESSING: begin
                        if (await_ff && stat.to_ok) begin
                           await_in = 1'b0;
                           mode_in  = ptt_pkg::MODE_READY;
                        end
                        if (!stat.link) begin
                           await_in = 1'b0;
                           mode_in  = ptt_pkg::MODE_CONNECTING;
                        end
                     end
                     ptt_pkg::MODE_SPEAKING: begin
                        if (stat.rem_zero && !await_ff) mode_in = ptt_pkg::MODE_READY;
                        if (samples != '0) begin
                           cnt_in   = samples;
                           state_in = ST_RD_LO;
                        end
                     end
                     default: ;
                  endcase
               end
               ptt_pkg::OP_AUDIO: cmd.ring_put = 1'b1;
               ptt_pkg::OP_SPEAK: mode_in = ptt_pkg::MODE_SPEAKING;
               ptt_pkg::OP_DONE: begin
                  await_in = 1'b0;
                  if (stat.fill_zero) mode_in = ptt_pkg::MODE_READY;
               end
               ptt_pkg::OP_ERROR: begin
                  mode_in = stat.link ? ptt_pkg::MODE_READY : ptt_pkg::MODE_CONNECTING;
               end
               default: ;
            endcase
            meta_in.mode         = mode_in;
            meta_in.mode_changed = (mode_in != mode_ff);
         end
         ST_OUT: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_RD_LO: begin
            cmd.ring_take = 1'b1;
            state_in      = ST_RD_HI;
         end
         ST_RD_HI: begin
            cmd.ring_take  = 1'b1;
            cmd.lo_capture = 1'b1;
            state_in       = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.out_load         = 1'b1;
               cmd.out_sample_valid = 1'b1;
               cmd.out_last         = (cnt_ff == SW'(1));
               cnt_in               = cnt_ff - SW'(1);
               state_in             = (cnt_ff == SW'(1)) ? ST_IDLE : ST_RD_LO;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff  <= ptt_pkg::MODE_IDLE;
         held_ff  <= 1'b0;
         await_ff <= 1'b0;
         meta_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         held_ff  <= held_in;
         await_ff <= await_in;
         meta_ff  <= meta_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

### hw/rtl/ptt_datapath.sv
// ----------------------------------------------------------------------------
// Push-to-talk datapath
// Word latch, settings, time compares, playback ring and result register.
// ----------------------------------------------------------------------------
`include "push_to_talk_voice_controller_core_macros.svh"

module ptt_datapath #(
   parameter int RING_BYTES    = 4096,
   parameter int CHUNK_SAMPLES = 32,
   localparam int PW          = $clog2(RING_BYTES),
   localparam int FW          = $clog2(RING_BYTES + 1),
   localparam int SW          = $clog2(CHUNK_SAMPLES + 1),
   localparam int DRAIN_BYTES = 2 * CHUNK_SAMPLES,
   localparam int DW          = $clog2(DRAIN_BYTES + 1),
   localparam int CW          = (FW > DW) ? FW : DW
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ptt_pkg::cmd_type                    cmd,
   output ptt_pkg::stat_type                   stat,
   output logic [SW-1:0]                       samples,
   input  logic [2:0]                          req_operation,
   input  logic [31:0]                         req_now_ms,
   input  logic                                req_wifi_up,
   input  logic                                req_link_up,
   input  logic                                req_button_down,
   input  logic                                req_muted,
   input  logic [7:0]                          req_data_byte,
   input  logic                                csr_we,
   input  logic [ptt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [ptt_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ptt_pkg::meta_type                   rsp_meta,
   output logic signed [15:0]                  rsp_sample,
   output logic                                rsp_sample_valid,
   output logic                                rsp_last
);

   logic [2:0]  op_ff;
   logic [31:0] now_ff;
   logic        wifi_ff, link_ff, btn_ff, muted_ff;
   logic [7:0]  byte_ff;

   logic [15:0] debounce_ff;
   logic [31:0] timeout_ff;
   logic [31:0] change_ff, release_ff;

   logic [7:0]    ring_mem [RING_BYTES];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0] fill_ff, fill_in;
   logic [7:0]    rd_data_ff, lo_ff;

   logic          out_valid_ff;
   ptt_pkg::meta_type out_meta_ff;
   logic signed [15:0] out_sample_ff;
   logic          out_sv_ff, out_last_ff;

   logic [31:0] deb_diff, to_diff;
   logic [CW-1:0] fill_ext, fill_half;
   logic          fill_ge;
   logic          out_free;

   assign deb_diff  = now_ff - change_ff;
   assign to_diff   = now_ff - release_ff;
   assign fill_ext  = CW'(fill_ff);
   assign fill_half = fill_ext >> 1;
   assign fill_ge   = (fill_ext >= CW'(DRAIN_BYTES));
   assign samples   = fill_ge ? SW'(CHUNK_SAMPLES) : SW'(fill_half);
   assign out_free  = !out_valid_ff || rsp_ready;

   always_comb begin
      stat           = '0;
      stat.op        = op_ff;
      stat.wifi      = wifi_ff;
      stat.link      = link_ff;
      stat.btn       = btn_ff;
      stat.muted     = muted_ff;
      stat.deb_ok    = (deb_diff > {16'd0, debounce_ff});
      stat.to_ok     = (to_diff > timeout_ff);
      stat.fill_zero = (fill_ff == '0);
      stat.rem_zero  = fill_ge ? (fill_ext == CW'(DRAIN_BYTES)) : !fill_ext[0];
      stat.out_free  = out_free;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (cmd.ring_clear) begin
         wr_ptr_in = '0;
         rd_ptr_in = '0;
         fill_in   = '0;
      end else if (cmd.ring_put) begin
         wr_ptr_in = (wr_ptr_ff == PW'(RING_BYTES - 1)) ? '0 : wr_ptr_ff + PW'(1);
         if (fill_ff == FW'(RING_BYTES)) begin
            rd_ptr_in = (rd_ptr_ff == PW'(RING_BYTES - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end else begin
            fill_in = fill_ff + FW'(1);
         end
      end else if (cmd.ring_take) begin
         rd_ptr_in = (rd_ptr_ff == PW'(RING_BYTES - 1)) ? '0 : rd_ptr_ff + PW'(1);
         fill_in   = fill_ff - FW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.item_load) begin
         op_ff    <= req_operation;
         now_ff   <= req_now_ms;
         wifi_ff  <= req_wifi_up;
         link_ff  <= req_link_up;
         btn_ff   <= req_button_down;
         muted_ff <= req_muted;
         byte_ff  <= req_data_byte;
      end
      if (cmd.ring_put) ring_mem[wr_ptr_ff] <= byte_ff;
      if (cmd.ring_take) rd_data_ff <= ring_mem[rd_ptr_ff];
      if (cmd.lo_capture) lo_ff <= rd_data_ff;
      if (cmd.out_load) begin
         out_meta_ff   <= cmd.meta;
         out_sample_ff <= cmd.out_sample_valid ? signed'({rd_data_ff, lo_ff}) : 16'sd0;
         out_sv_ff     <= cmd.out_sample_valid;
         out_last_ff   <= cmd.out_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff  <= ptt_pkg::DEBOUNCE_RESET;
         timeout_ff   <= ptt_pkg::TIMEOUT_RESET;
         change_ff    <= '0;
         release_ff   <= '0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we && csr_index == ptt_pkg::CSR_DEBOUNCE) debounce_ff <= csr_wdata[15:0];
         if (csr_we && csr_index == ptt_pkg::CSR_TIMEOUT) timeout_ff <= csr_wdata;
         if (cmd.set_change) change_ff <= now_ff;
         if (cmd.set_release) release_ff <= now_ff;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
         if (cmd.out_load) out_valid_ff <= 1'b1;
         else if (rsp_ready) out_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_meta         = out_meta_ff;
   assign rsp_sample       = out_sample_ff;
   assign rsp_sample_valid = out_sv_ff;
   assign rsp_last         = out_last_ff;

   `PTT_ASSERT_IMP(a_take_nonempty, clock, reset, cmd.ring_take, fill_ff != '0)
   `PTT_ASSERT_IMP(a_load_when_free, clock, reset, cmd.out_load, out_free)
   `PTT_ASSERT_IMP(a_fill_bound, clock, reset, cmd.ring_put || cmd.ring_take,
                   fill_ff <= FW'(RING_BYTES))
   `PTT_ASSERT_NXT(a_put_advances, clock, reset, cmd.ring_put && !cmd.ring_clear,
                   wr_ptr_ff != $past(wr_ptr_ff))

endmodule

### hw/rtl/push_to_talk_voice_controller_core.sv
// ----------------------------------------------------------------------------
// Push-to-talk voice controller core
// Six-mode link controller with a byte playback ring and sample drain.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan takes one word at a time: a tick, an audio byte, or a speaking,
//   done or error notice. rsp_chan returns one or more words per request,
//   the final one flagged by last. csr_* writes the debounce and response
//   timeout settings; write them only while the core is idle.
//   A word without samples is accepted, evaluated in the next cycle and
//   then loaded into the result register once it is free, so a new
//   request is taken only after the last result is loaded. A speaking tick
//   drains up to CHUNK_SAMPLES samples, each from two byte reads through
//   the single read port of the ring memory and one result load.
//   Reset returns the mode to idle, empties the ring and restores the
//   settings to 50 ms and 30000 ms. The ring contents are not cleared.
//   A stalled rsp_chan holds the result register; the sequencer waits on it
//   and req_chan stays not ready until the pending results are loaded.
// ----------------------------------------------------------------------------
module push_to_talk_voice_controller_core #(
   parameter int RING_BYTES    = 4096,
   parameter int CHUNK_SAMPLES = 32,
   localparam int SW = $clog2(CHUNK_SAMPLES + 1)
) (
   input  logic                            clock,
   input  logic                            reset,
   ptt_req_if.sink                         req_chan,
   ptt_rsp_if.source                       rsp_chan,
   input  logic                            csr_we,
   input  logic [ptt_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ptt_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   ptt_pkg::cmd_type  cmd;
   ptt_pkg::stat_type stat;
   ptt_pkg::meta_type rsp_meta;
   logic [SW-1:0]     samples;

   ptt_ctrl #(.CHUNK_SAMPLES(CHUNK_SAMPLES)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .samples   (samples),
      .cmd       (cmd)
   );

   ptt_datapath #(.RING_BYTES(RING_BYTES), .CHUNK_SAMPLES(CHUNK_SAMPLES)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .samples          (samples),
      .req_operation    (req_chan.operation),
      .req_now_ms       (req_chan.now_ms),
      .req_wifi_up      (req_chan.wifi_up),
      .req_link_up      (req_chan.link_up),
      .req_button_down  (req_chan.button_down),
      .req_muted        (req_chan.muted),
      .req_data_byte    (req_chan.data_byte),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_chan.valid),
      .rsp_ready        (rsp_chan.ready),
      .rsp_meta         (rsp_meta),
      .rsp_sample       (rsp_chan.sample),
      .rsp_sample_valid (rsp_chan.sample_valid),
      .rsp_last         (rsp_chan.last)
   );

   assign rsp_chan.mode            = rsp_meta.mode;
   assign rsp_chan.mode_changed    = rsp_meta.mode_changed;
   assign rsp_chan.request_connect = rsp_meta.request_connect;
   assign rsp_chan.send_config     = rsp_meta.send_config;
   assign rsp_chan.send_end_audio  = rsp_meta.send_end_audio;
   assign rsp_chan.capture_enable  = rsp_meta.capture_enable;

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// Push-to-talk voice controller testbench
// Sends tick, audio byte and notice words through the request channel while
// both channels idle and stall at random. Every result word is checked in
// order against a local prediction of modes, strobes and drained samples.
// A short scripted sequence comes first, then random sessions under several
// debounce and timeout settings, including a multi-chunk fill and drain.
// ----------------------------------------------------------------------------
module tb;

   localparam int RING_BYTES    = 4096;
   localparam int CHUNK_SAMPLES = 32;
   localparam int PW            = $clog2(RING_BYTES);
   localparam int RX_HOLD       = 400;
   localparam logic [2:0] OP_UNKNOWN = 3'd7;

   typedef struct packed {
      logic [2:0]  op;
      logic [31:0] now_ms;
      logic        wifi;
      logic        link;
      logic        btn;
      logic        muted;
      logic [7:0]  data;
   } req_word_type;

   typedef struct packed {
      ptt_pkg::mode_type mode;
      logic        mode_changed;
      logic [15:0] sample;
      logic        sample_valid;
      logic        last;
      logic        request_connect;
      logic        send_config;
      logic        send_end_audio;
      logic        capture_enable;
   } rsp_word_type;

   typedef struct {
      req_word_type w;
      bit           typed;
      rsp_word_type r;
   } script_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                            csr_we;
   logic [ptt_pkg::CSR_INDEX_W-1:0] csr_index;
   logic [ptt_pkg::CSR_DATA_W-1:0]  csr_wdata;

   ptt_req_if req_chan ();
   ptt_rsp_if rsp_chan ();

   push_to_talk_voice_controller_core #(
      .RING_BYTES    (RING_BYTES),
      .CHUNK_SAMPLES (CHUNK_SAMPLES)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted controller state
   ptt_pkg::mode_type ctl_mode;
   logic        btn_held;
   logic [31:0] last_change;
   logic [31:0] release_at;
   logic        awaiting;
   logic [7:0]  ring_mem [RING_BYTES];
   int          wr_ptr;
   int          rd_ptr;
   int          fill_bytes;
   logic [15:0] deb_ms;
   logic [31:0] resp_timeout;

   rsp_word_type pending_rsp [$];
   rsp_word_type want;
   rsp_word_type got;
   int           fault_count = 0;
   logic [31:0]  clock_ms;
   bit           calm = 1'b0;
   bit           rx_hold_req = 1'b0;
   script_row_type script [$];

   function automatic int pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic req_word_type word_in(logic [2:0] op, logic [31:0] now_ms, logic wifi,
                                            logic link, logic btn, logic muted,
                                            logic [7:0] data);
      req_word_type w;
      w = '{op: op, now_ms: now_ms, wifi: wifi, link: link, btn: btn, muted: muted,
            data: data};
      return w;
   endfunction

   function automatic rsp_word_type meta_out(ptt_pkg::mode_type mode, logic chg, logic rc,
                                             logic sc, logic se, logic ce);
      rsp_word_type r;
      r = '0;
      r.mode = mode;
      r.mode_changed = chg;
      r.last = 1'b1;
      r.request_connect = rc;
      r.send_config = sc;
      r.send_end_audio = se;
      r.capture_enable = ce;
      return r;
   endfunction

   // advance the predicted controller by one word and queue its results
   task automatic step_controller(input req_word_type w);
      ptt_pkg::mode_type prior;
      logic         rc, sc, se, ce;
      logic [31:0]  since_change;
      logic [31:0]  since_release;
      logic [15:0]  drained [$];
      int           n;
      rsp_word_type r;
      prior = ctl_mode;
      rc = 1'b0;
      sc = 1'b0;
      se = 1'b0;
      ce = 1'b0;
      since_change = w.now_ms - last_change;
      since_release = w.now_ms - release_at;
      case (w.op)
         ptt_pkg::OP_TICK: begin
            case (ctl_mode)
               ptt_pkg::MODE_IDLE: begin
                  if (w.wifi) begin
                     ctl_mode = ptt_pkg::MODE_CONNECTING;
                     rc = 1'b1;
                  end
               end
               ptt_pkg::MODE_CONNECTING: begin
                  if (w.link) begin
                     ctl_mode = ptt_pkg::MODE_READY;
                     sc = 1'b1;
                  end
                  if (!w.wifi) ctl_mode = ptt_pkg::MODE_IDLE;
               end
               ptt_pkg::MODE_READY: begin
                  if (w.btn && !btn_held && since_change > {16'd0, deb_ms}) begin
                     btn_held = 1'b1;
                     last_change = w.now_ms;
                     wr_ptr = 0;
                     rd_ptr = 0;
                     fill_bytes = 0;
                     ctl_mode = ptt_pkg::MODE_LISTENING;
                  end
                  if (!w.btn && btn_held) begin
                     btn_held = 1'b0;
                     last_change = w.now_ms;
                  end
                  if (!w.link) ctl_mode = ptt_pkg::MODE_CONNECTING;
               end
               ptt_pkg::MODE_LISTENING: begin
                  ce = !w.muted;
                  if (!w.btn && since_change > {16'd0, deb_ms}) begin
                     btn_held = 1'b0;
                     last_change = w.now_ms;
                     release_at = w.now_ms;
                     awaiting = 1'b1;
                     se = 1'b1;
                     ctl_mode = ptt_pkg::MODE_PROCESSING;
                  end
               end
               ptt_pkg::MODE_PROCESSING: begin
                  if (awaiting && since_release > resp_timeout) begin
                     awaiting = 1'b0;
                     ctl_mode = ptt_pkg::MODE_READY;
                  end
                  if (!w.link) begin
                     awaiting = 1'b0;
                     ctl_mode = ptt_pkg::MODE_CONNECTING;
                  end
               end
               ptt_pkg::MODE_SPEAKING: begin
                  n = (fill_bytes < 2 * CHUNK_SAMPLES) ? fill_bytes : 2 * CHUNK_SAMPLES;
                  n = n & ~1;
                  while (n >= 2 && drained.size() < CHUNK_SAMPLES) begin
                     drained.push_back({ring_mem[PW'((rd_ptr + 1) % RING_BYTES)],
                                        ring_mem[PW'(rd_ptr)]});
                     rd_ptr = (rd_ptr + 2) % RING_BYTES;
                     fill_bytes -= 2;
                     n -= 2;
                  end
                  if (fill_bytes == 0 && !awaiting) ctl_mode = ptt_pkg::MODE_READY;
               end
               default: ;
            endcase
         end
         ptt_pkg::OP_AUDIO: begin
            if (fill_bytes >= RING_BYTES) begin
               rd_ptr = (rd_ptr + 1) % RING_BYTES;
               fill_bytes--;
            end
            ring_mem[PW'(wr_ptr)] = w.data;
            wr_ptr = (wr_ptr + 1) % RING_BYTES;
            fill_bytes++;
         end
         ptt_pkg::OP_SPEAK: ctl_mode = ptt_pkg::MODE_SPEAKING;
         ptt_pkg::OP_DONE: begin
            awaiting = 1'b0;
            if (fill_bytes == 0) ctl_mode = ptt_pkg::MODE_READY;
         end
         ptt_pkg::OP_ERROR: begin
            if (w.link) ctl_mode = ptt_pkg::MODE_READY;
            else ctl_mode = ptt_pkg::MODE_CONNECTING;
         end
         default: ;
      endcase
      r = meta_out(ctl_mode, ctl_mode != prior, rc, sc, se, ce);
      if (drained.size() == 0) begin
         pending_rsp.push_back(r);
      end else begin
         r.sample_valid = 1'b1;
         foreach (drained[k]) begin
            r.sample = drained[k];
            r.last = (k == drained.size() - 1);
            pending_rsp.push_back(r);
         end
      end
   endtask

   // random word steered by the predicted mode so that sessions go deep
   function automatic req_word_type next_item();
      req_word_type w;
      int unsigned  r;
      if ($urandom_range(0, 99) < 4) clock_ms = $urandom();
      else clock_ms = clock_ms + $urandom_range(0, 150);
      w = word_in(ptt_pkg::OP_TICK, clock_ms, 1'b1, 1'b1, 1'($urandom_range(0, 1)),
                  $urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
      r = $urandom_range(0, 99);
      if (r < 10) begin
         w.op = 3'($urandom_range(0, 7));
         w.wifi = 1'($urandom_range(0, 1));
         w.link = 1'($urandom_range(0, 1));
         return w;
      end
      case (ctl_mode)
         ptt_pkg::MODE_IDLE: w.wifi = (r % 5) != 0;
         ptt_pkg::MODE_CONNECTING: begin
            w.wifi = $urandom_range(0, 9) != 0;
            w.link = $urandom_range(0, 4) != 0;
         end
         ptt_pkg::MODE_READY: begin
            w.link = $urandom_range(0, 19) != 0;
            w.btn = $urandom_range(0, 3) != 0;
            if (r < 25) w.now_ms = last_change + {16'd0, deb_ms} + $urandom_range(0, 1);
            else if (r < 32) w.op = ptt_pkg::OP_AUDIO;
         end
         ptt_pkg::MODE_LISTENING: begin
            w.btn = $urandom_range(0, 2) == 0;
            w.link = 1'($urandom_range(0, 1));
            if (r < 30) w.now_ms = last_change + {16'd0, deb_ms} + $urandom_range(0, 1);
            else if (r < 38) w.op = ptt_pkg::OP_AUDIO;
         end
         ptt_pkg::MODE_PROCESSING: begin
            if (r < 60) w.op = ptt_pkg::OP_AUDIO;
            else if (r < 70) w.op = ptt_pkg::OP_SPEAK;
            else if (r < 78) w.op = ptt_pkg::OP_DONE;
            else if (r < 83) begin
               w.op = ptt_pkg::OP_ERROR;
               w.link = 1'($urandom_range(0, 1));
            end else begin
               w.link = $urandom_range(0, 14) != 0;
               if (r < 92) w.now_ms = release_at + resp_timeout + $urandom_range(0, 1);
            end
         end
         ptt_pkg::MODE_SPEAKING: begin
            if (r < 30) w.op = ptt_pkg::OP_AUDIO;
            else if (r < 38) w.op = ptt_pkg::OP_DONE;
            else if (r < 42) begin
               w.op = ptt_pkg::OP_ERROR;
               w.link = 1'($urandom_range(0, 1));
            end
         end
         default: ;
      endcase
      clock_ms = w.now_ms;
      return w;
   endfunction

   task automatic send_word(input req_word_type w, input bit typed, input rsp_word_type r);
      int gap;
      step_controller(w);
      if (typed) pending_rsp[pending_rsp.size() - 1] = r;
      @(negedge clock);
      req_chan.valid = 1'b1;
      req_chan.operation = w.op;
      req_chan.now_ms = w.now_ms;
      req_chan.wifi_up = w.wifi;
      req_chan.link_up = w.link;
      req_chan.button_down = w.btn;
      req_chan.muted = w.muted;
      req_chan.data_byte = w.data;
      do @(posedge clock); while (!req_chan.ready);
      gap = calm ? 0 : pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_chan.valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_chan.valid = 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [ptt_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [ptt_pkg::CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      if (idx == ptt_pkg::CSR_DEBOUNCE) deb_ms = data[15:0];
      else resp_timeout = data;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic run_random(input int count);
      repeat (count) begin
         if ($urandom_range(0, 29) == 0) calm = !calm;
         send_word(next_item(), 1'b0, '0);
      end
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got.mode = ptt_pkg::mode_type'(rsp_chan.mode);
         got.mode_changed = rsp_chan.mode_changed;
         got.sample = rsp_chan.sample;
         got.sample_valid = rsp_chan.sample_valid;
         got.last = rsp_chan.last;
         got.request_connect = rsp_chan.request_connect;
         got.send_config = rsp_chan.send_config;
         got.send_end_audio = rsp_chan.send_end_audio;
         got.capture_enable = rsp_chan.capture_enable;
         if (pending_rsp.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("unexpected rsp word: mode %0d sample %h", got.mode, got.sample);
         end else begin
            want = pending_rsp.pop_front();
            if (got !== want) begin
               fault_count++;
               if (fault_count <= 10)
                  $display({"rsp mismatch: want mode %0d chg %b smp %h sv %b last %b",
                            " rc/sc/se/ce %b%b%b%b; got mode %0d chg %b smp %h sv %b",
                            " last %b rc/sc/se/ce %b%b%b%b"},
                           want.mode, want.mode_changed, want.sample, want.sample_valid,
                           want.last, want.request_connect, want.send_config,
                           want.send_end_audio, want.capture_enable,
                           got.mode, got.mode_changed, got.sample, got.sample_valid,
                           got.last, got.request_connect, got.send_config,
                           got.send_end_audio, got.capture_enable);
            end
         end
      end
   end

   // result-side backpressure
   initial begin
      int ready_left;
      int stall_left;
      int hold_left;
      ready_left = 0;
      stall_left = 0;
      hold_left = 0;
      rsp_chan.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            hold_left = RX_HOLD;
         end
         if (hold_left > 0) begin
            rsp_chan.ready = 1'b0;
            hold_left--;
         end else if (ready_left > 0) begin
            rsp_chan.ready = 1'b1;
            ready_left--;
         end else if (stall_left > 0) begin
            rsp_chan.ready = 1'b0;
            stall_left--;
         end else begin
            rsp_chan.ready = 1'b1;
            ready_left = $urandom_range(0, 23);
            stall_left = calm ? 0 : pick_gap();
         end
      end
   end

   initial begin
      #30_000_000;
      $display("tb: errors");
      $finish;
   end

   initial begin
      req_chan.valid = 1'b0;
      req_chan.operation = ptt_pkg::OP_TICK;
      req_chan.now_ms = '0;
      req_chan.wifi_up = 1'b0;
      req_chan.link_up = 1'b0;
      req_chan.button_down = 1'b0;
      req_chan.muted = 1'b0;
      req_chan.data_byte = '0;
      csr_we = 1'b0;
      csr_index = ptt_pkg::CSR_DEBOUNCE;
      csr_wdata = '0;

      ctl_mode = ptt_pkg::MODE_IDLE;
      btn_held = 1'b0;
      last_change = '0;
      release_at = '0;
      awaiting = 1'b0;
      wr_ptr = 0;
      rd_ptr = 0;
      fill_bytes = 0;
      deb_ms = ptt_pkg::DEBOUNCE_RESET;
      resp_timeout = ptt_pkg::TIMEOUT_RESET;

      // scripted session at reset settings
      script.push_back('{word_in(ptt_pkg::OP_TICK, 32'd0, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00),
                         1'b1,
                         meta_out(ptt_pkg::MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)});
      script.push_back('{word_in(OP_UNKNOWN, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 8'hFF),
                         1'b1,
                         meta_out(ptt_pkg::MODE_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)});
      script.push_back('{word_in(ptt_pkg::OP_TICK, 32'd10, 1'b1, 1'b0, 1'b0, 1'b0, 8'h00),
                         1'b1,
                         meta_out(ptt_pkg::MODE_CONNECTING, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0)});
      script.push_back('{word_in(ptt_pkg::OP_TICK, 32'd20, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00),
                         1'b1,
                         meta_out(ptt_pkg::MODE_READY, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0)});
      // press exactly at the debounce limit does not count
      script.push_back('{word_in(ptt_pkg::OP_TICK, 32'd50, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00),
                         1'b1,
                         meta_out(ptt_pkg::MODE_READY, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)});
      script.push_back('{word_in(ptt_pkg::OP_TICK, 32'd51, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00),
                         1'b1,
                         meta_out(ptt_pkg::MODE_LISTENING, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)});
      // listening ignores the link flag
      script.push_back('{word_in(ptt_pkg::OP_TICK, 32'd60, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00),
                         1'b1,
                         meta_out(ptt_pkg::MODE_LISTENING, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1)});
      script.push_back('{word_in(ptt_pkg::OP_TICK, 32'd101, 1'b1, 1'b1, 1'b0, 1'b1, 8'h00),
                         1'b1,
                         meta_out(ptt_pkg::MODE_LISTENING, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)});
      script.push_back('{word_in(ptt_pkg::OP_TICK, 32'd102, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00),
                         1'b1,
                         meta_out(ptt_pkg::MODE_PROCESSING, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1)});
      script.push_back('{word_in(ptt_pkg::OP_AUDIO, 32'd103, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00),
                         1'b0, '0});
      script.push_back('{word_in(ptt_pkg::OP_AUDIO, 32'd104, 1'b1, 1'b1, 1'b0, 1'b0, 8'hFF),
                         1'b0, '0});
      script.push_back('{word_in(ptt_pkg::OP_AUDIO, 32'd105, 1'b1, 1'b1, 1'b0, 1'b0, 8'h80),
                         1'b0, '0});
      script.push_back('{word_in(ptt_pkg::OP_AUDIO, 32'd106, 1'b1, 1'b1, 1'b0, 1'b0, 8'h7F),
                         1'b0, '0});
      script.push_back('{word_in(ptt_pkg::OP_AUDIO, 32'd107, 1'b1, 1'b1, 1'b0, 1'b0, 8'h5A),
                         1'b0, '0});
      script.push_back('{word_in(ptt_pkg::OP_SPEAK, 32'd108, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00),
                         1'b1,
                         meta_out(ptt_pkg::MODE_SPEAKING, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)});
      script.push_back('{word_in(ptt_pkg::OP_TICK, 32'd109, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00),
                         1'b0, '0});
      // odd byte left behind keeps speaking alive
      script.push_back('{word_in(ptt_pkg::OP_DONE, 32'd110, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00),
                         1'b1,
                         meta_out(ptt_pkg::MODE_SPEAKING, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)});
      script.push_back('{word_in(ptt_pkg::OP_TICK, 32'd111, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00),
                         1'b1,
                         meta_out(ptt_pkg::MODE_SPEAKING, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)});
      script.push_back('{word_in(ptt_pkg::OP_ERROR, 32'd112, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00),
                         1'b1,
                         meta_out(ptt_pkg::MODE_READY, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)});
      // press with link loss: ring cleared, mode falls back
      script.push_back('{word_in(ptt_pkg::OP_TICK, 32'd200, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00),
                         1'b1,
                         meta_out(ptt_pkg::MODE_CONNECTING, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)});
      // connect with wifi loss in one tick
      script.push_back('{word_in(ptt_pkg::OP_TICK, 32'd210, 1'b0, 1'b1, 1'b1, 1'b0, 8'h00),
                         1'b1,
                         meta_out(ptt_pkg::MODE_IDLE, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0)});
      script.push_back('{word_in(ptt_pkg::OP_ERROR, 32'd215, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00),
                         1'b1,
                         meta_out(ptt_pkg::MODE_CONNECTING, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0)});
      script.push_back('{word_in(ptt_pkg::OP_TICK, 32'd220, 1'b1, 1'b1, 1'b1, 1'b0, 8'h00),
                         1'b1,
                         meta_out(ptt_pkg::MODE_READY, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0)});
      script.push_back('{word_in(ptt_pkg::OP_TICK, 32'd230, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00),
                         1'b1,
                         meta_out(ptt_pkg::MODE_READY, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0)});

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (script[i]) send_word(script[i].w, script[i].typed, script[i].r);
      clock_ms = $urandom();

      drain_results();
      write_reg(ptt_pkg::CSR_DEBOUNCE, '0);
      write_reg(ptt_pkg::CSR_TIMEOUT, '0);
      run_random(100);

      drain_results();
      write_reg(ptt_pkg::CSR_DEBOUNCE, 32'h0000_FFFF);
      write_reg(ptt_pkg::CSR_TIMEOUT, 32'hFFFF_FFFF);
      run_random(80);

      drain_results();
      write_reg(ptt_pkg::CSR_DEBOUNCE, {16'($urandom()), 16'($urandom_range(1, 300))});
      write_reg(ptt_pkg::CSR_TIMEOUT, $urandom_range(100, 5000));
      run_random(50);
      rx_hold_req = 1'b1;
      run_random(30);
      drain_results();
      run_random(30);

      // fill several chunks plus an odd byte, then drain
      drain_results();
      write_reg(ptt_pkg::CSR_DEBOUNCE, {16'd0, ptt_pkg::DEBOUNCE_RESET});
      write_reg(ptt_pkg::CSR_TIMEOUT, ptt_pkg::TIMEOUT_RESET);
      calm = 1'b1;
      repeat (4 * CHUNK_SAMPLES + 5)
         send_word(word_in(ptt_pkg::OP_AUDIO, clock_ms, 1'b1, 1'b1, 1'b0, 1'b0,
                           8'($urandom_range(0, 255))), 1'b0, '0);
      send_word(word_in(ptt_pkg::OP_SPEAK, clock_ms, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00),
                1'b0, '0);
      calm = 1'b0;
      while (ctl_mode == ptt_pkg::MODE_SPEAKING && fill_bytes >= 2)
         send_word(word_in(ptt_pkg::OP_TICK, clock_ms, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00),
                   1'b0, '0);
      send_word(word_in(ptt_pkg::OP_DONE, clock_ms, 1'b1, 1'b1, 1'b0, 1'b0, 8'h00),
                1'b0, '0);
      run_random(50);

      drain_results();
      repeat (20) @(posedge clock);
      if (fault_count == 0 && pending_rsp.size() == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/ptt_pkg.sv
hw/rtl/ptt_req_if.sv
hw/rtl/ptt_rsp_if.sv
hw/rtl/ptt_ctrl.sv
hw/rtl/ptt_datapath.sv
hw/rtl/push_to_talk_voice_controller_core.sv
verif/tb.sv
